// File: sv/bigsize_tlv_stream_router_core_defines.svh
// Assertion macros shared by the checker of the BigSize TLV stream router.
// No dependencies; expects clk_i and rst_ni in the scope of use.
`ifndef BIGSIZE_TLV_STREAM_ROUTER_CORE_DEFINES_SVH
`define BIGSIZE_TLV_STREAM_ROUTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BSTR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bstr: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define BSTR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bstr: next-cycle check failed");

`endif

// File: sv/bstr_pkg.sv
// Shared types and constants of the BigSize TLV stream router.
// No dependencies.
package bstr_pkg;

  // Parameter defaults
  localparam int unsigned PAYLOAD_MAX_DEF = 2048;
  localparam int unsigned INNER_MAX_DEF   = 1024;
  localparam int unsigned APP_MAX_DEF     = 512;

  // Item kinds
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // Result event codes
  localparam logic [1:0] EVT_NONE   = 2'd0;
  localparam logic [1:0] EVT_HEADER = 2'd1;
  localparam logic [1:0] EVT_VALUE  = 2'd2;

  // Route codes
  localparam logic [1:0] ROUTE_NEXT_NODE = 2'd0;
  localparam logic [1:0] ROUTE_INNER     = 2'd1;
  localparam logic [1:0] ROUTE_APP       = 2'd2;

  // Parse status codes
  localparam logic [1:0] STAT_CLEAN     = 2'd0;
  localparam logic [1:0] STAT_TRUNCATED = 2'd1;
  localparam logic [1:0] STAT_OVERRUN   = 2'd2;

  // BigSize prefixes, record type constants and the next-node record length
  localparam logic [7:0]  BIGSIZE_PFX_2  = 8'hfd;
  localparam logic [7:0]  BIGSIZE_PFX_4  = 8'hfe;
  localparam logic [63:0] TYPE_NEXT_NODE = 64'd4;
  localparam logic [63:0] TYPE_INNER     = 64'd6;
  localparam logic [11:0] NEXT_NODE_LEN  = 12'd33;

  typedef struct packed {
    logic        func;
    logic [11:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  route;
    logic [7:0]  data_out;
    logic [63:0] record_type;
    logic [10:0] record_length;
    logic        packet_done;
    logic        final_hop;
    logic [1:0]  parse_status;
  } out_item_t;

endpackage

// File: sv/bstr_parser.sv
// Parser state and per-byte TLV decode for the stream router.
// Depends on bstr_pkg.
module bstr_parser import bstr_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  parameter int unsigned INNER_MAX   = INNER_MAX_DEF,
  parameter int unsigned APP_MAX     = APP_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  localparam logic [16:0] PayloadLim = 17'(PAYLOAD_MAX);
  localparam logic [16:0] InnerLim   = 17'(INNER_MAX);
  localparam logic [16:0] AppLim     = 17'(APP_MAX);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_TYPE_FIRST = 3'd1,
    PH_TYPE_MORE  = 3'd2,
    PH_LEN_FIRST  = 3'd3,
    PH_LEN_MORE   = 3'd4,
    PH_VALUE      = 3'd5,
    PH_STOP       = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  bsl_q, bsl_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] held_type_q, held_type_d;
  logic [11:0] rem_q, rem_d;
  logic [11:0] vbl_q, vbl_d;
  logic [1:0]  route_q, route_d;
  logic        rec_acc_q, rec_acc_d;
  logic        saw_next_q, saw_next_d;
  logic [1:0]  stop_q, stop_d;

  logic [7:0]  b;
  logic [11:0] rem_dec;
  logic [3:0]  bsl_dec;
  logic [11:0] vbl_dec;
  logic [3:0]  pfx_n;
  logic [11:0] len_sat;
  logic        is_prefix;
  logic        field_done;
  logic        field_is_len;
  logic [11:0] v12;
  logic        v_over;

  assign b         = item_i.data_byte;
  assign rem_dec   = rem_q - 12'd1;
  assign bsl_dec   = (bsl_q != 4'd0) ? bsl_q - 4'd1 : 4'd0;
  assign vbl_dec   = (vbl_q != 12'd0) ? vbl_q - 12'd1 : 12'd0;
  assign is_prefix = (b >= BIGSIZE_PFX_2);
  assign pfx_n     = (b == BIGSIZE_PFX_2) ? 4'd2 : ((b == BIGSIZE_PFX_4) ? 4'd4 : 4'd8);
  assign len_sat   = ({5'd0, item_i.payload_length} > PayloadLim) ?
                     PayloadLim[11:0] : item_i.payload_length;

  // Next state and result for one accepted transaction
  always_comb begin
    phase_d      = phase_q;
    bsl_d        = bsl_q;
    acc_d        = acc_q;
    held_type_d  = held_type_q;
    rem_d        = rem_q;
    vbl_d        = vbl_q;
    route_d      = route_q;
    rec_acc_d    = rec_acc_q;
    saw_next_d   = saw_next_q;
    stop_d       = stop_q;
    result_o     = '0;
    field_done   = 1'b0;
    field_is_len = (phase_q == PH_LEN_FIRST) || (phase_q == PH_LEN_MORE);
    v12          = '0;
    v_over       = 1'b0;

    if (accept_i) begin
      if (item_i.func == FUNC_START) begin
        // New packet: clear everything, load saturated length
        bsl_d       = '0;
        acc_d       = '0;
        held_type_d = '0;
        vbl_d       = '0;
        route_d     = '0;
        rec_acc_d   = 1'b0;
        saw_next_d  = 1'b0;
        stop_d      = STAT_CLEAN;
        rem_d       = len_sat;
        phase_d     = (len_sat != 12'd0) ? PH_TYPE_FIRST : PH_IDLE;
      end else if (phase_q != PH_IDLE && rem_q != 12'd0) begin
        rem_d = rem_dec;
        unique case (phase_q)
          PH_TYPE_FIRST, PH_LEN_FIRST: begin
            if (!is_prefix) begin
              acc_d      = {56'd0, b};
              field_done = 1'b1;
            end else if ({8'd0, pfx_n} > rem_dec) begin
              stop_d  = STAT_TRUNCATED;
              phase_d = PH_STOP;
            end else begin
              acc_d   = '0;
              bsl_d   = pfx_n;
              phase_d = field_is_len ? PH_LEN_MORE : PH_TYPE_MORE;
            end
          end
          PH_TYPE_MORE, PH_LEN_MORE: begin
            acc_d = {acc_q[55:0], b};
            bsl_d = bsl_dec;
            field_done = (bsl_dec == 4'd0);
          end
          PH_VALUE: begin
            if (rec_acc_q) begin
              result_o.event_res = EVT_VALUE;
              result_o.route     = route_q;
              result_o.data_out  = b;
            end
            vbl_d = vbl_dec;
            if (vbl_dec == 12'd0) begin
              phase_d = PH_TYPE_FIRST;
            end
          end
          default: begin
          end
        endcase

        // Completed BigSize field
        if (field_done) begin
          if (!field_is_len) begin
            held_type_d = acc_d;
            if (rem_dec == 12'd0) begin
              stop_d  = STAT_TRUNCATED;
              phase_d = PH_STOP;
            end else begin
              phase_d = PH_LEN_FIRST;
            end
          end else begin
            v12    = acc_d[11:0];
            v_over = (|acc_d[63:12]) || (v12 > rem_dec);
            if (v_over) begin
              stop_d  = STAT_OVERRUN;
              phase_d = PH_STOP;
            end else begin
              rec_acc_d = 1'b0;
              if (held_type_q == TYPE_NEXT_NODE) begin
                if (v12 == NEXT_NODE_LEN) begin
                  rec_acc_d  = 1'b1;
                  route_d    = ROUTE_NEXT_NODE;
                  saw_next_d = 1'b1;
                end
              end else if (held_type_q == TYPE_INNER) begin
                if ({5'd0, v12} <= InnerLim) begin
                  rec_acc_d = 1'b1;
                  route_d   = ROUTE_INNER;
                end
              end else if (!saw_next_q && ({5'd0, v12} <= AppLim)) begin
                rec_acc_d = 1'b1;
                route_d   = ROUTE_APP;
              end
              if (rec_acc_d) begin
                result_o.event_res     = EVT_HEADER;
                result_o.route         = route_d;
                result_o.record_type   = held_type_q;
                result_o.record_length = v12[10:0];
              end
              vbl_d   = v12;
              phase_d = (v12 != 12'd0) ? PH_VALUE : PH_TYPE_FIRST;
            end
          end
        end

        // Last payload byte reports the packet outcome
        if (rem_dec == 12'd0) begin
          result_o.packet_done  = 1'b1;
          result_o.final_hop    = ~saw_next_d;
          result_o.parse_status = (phase_d == PH_STOP) ? stop_d : STAT_CLEAN;
          phase_d = PH_IDLE;
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bsl_q       <= '0;
      acc_q       <= '0;
      held_type_q <= '0;
      rem_q       <= '0;
      vbl_q       <= '0;
      route_q     <= '0;
      rec_acc_q   <= 1'b0;
      saw_next_q  <= 1'b0;
      stop_q      <= STAT_CLEAN;
    end else begin
      phase_q     <= phase_d;
      bsl_q       <= bsl_d;
      acc_q       <= acc_d;
      held_type_q <= held_type_d;
      rem_q       <= rem_d;
      vbl_q       <= vbl_d;
      route_q     <= route_d;
      rec_acc_q   <= rec_acc_d;
      saw_next_q  <= saw_next_d;
      stop_q      <= stop_d;
    end
  end

endmodule

// File: sv/bstr_obuf.sv
// Result register with skid stage for the stream router output channel.
// Depends on bstr_pkg.
module bstr_obuf import bstr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  out_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      out_valid_q;
  logic      skid_valid_q;
  out_item_t out_item_q;
  out_item_t skid_item_q;
  logic      accept;
  logic      out_free;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Control: output register refills from skid first, then from input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_item_q <= skid_item_q;
      end else if (accept) begin
        out_item_q <= in_item_i;
      end
    end else if (accept) begin
      skid_item_q <= in_item_i;
    end
  end

endmodule

// File: sv/bigsize_tlv_stream_router_core.sv
// BigSize TLV stream router: top level.
// Depends on bstr_pkg, bstr_parser and bstr_obuf.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): a start transaction
// (func 0) loads the payload length; each byte transaction (func 1) carries
// one decrypted payload byte. Every accepted transaction yields exactly one
// result transaction on the output channel (out_valid_o / out_stall_i /
// out_data_o): a record header, a routed value byte, or an empty result,
// with packet_done, final_hop and parse_status set on the last payload byte.
// The result is registered in the output register, or in the skid register
// when the receiver stalls. Throughput: one transaction per cycle while
// in_stall_o is low; the parser updates its counters and the 64-bit BigSize
// accumulator combinationally between input handshake and result register.
// When the receiver stalls, the held result stays put and one further
// transaction is taken into a skid register; in_stall_o then rises until
// the output register drains.
// Reset puts the parser in idle with all counters cleared and both output
// registers empty; byte transactions seen while idle give empty results.
module bigsize_tlv_stream_router_core import bstr_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  parameter int unsigned INNER_MAX   = INNER_MAX_DEF,
  parameter int unsigned APP_MAX     = APP_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      in_accept;
  out_item_t result;

  assign in_accept = in_valid_i & ~in_stall_o;

  // Decode
  bstr_parser #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .INNER_MAX   (INNER_MAX),
    .APP_MAX     (APP_MAX)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .result_o (result)
  );

  // Result register and skid
  bstr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_data_o)
  );

endmodule

// File: sv/bstr_checker.sv
// Port-level checks for the BigSize TLV stream router, bound to the top.
// Depends on bstr_pkg and bigsize_tlv_stream_router_core_defines.svh.
`include "bigsize_tlv_stream_router_core_defines.svh"

module bstr_checker import bstr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result transaction holds
  `BSTR_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Input stall only while a result is waiting
  `BSTR_ASSERT_IMP(a_stall_needs_out, in_stall_o, out_valid_o)

  // Accepted transaction into an empty output shows up next cycle
  `BSTR_ASSERT_NXT(a_lat_one, in_valid_i && !in_stall_o && !out_valid_o, out_valid_o)

  // Packet outcome fields stay zero except on the last byte
  `BSTR_ASSERT_IMP(a_done_fields, out_valid_o && !out_data_o.packet_done, !out_data_o.final_hop && out_data_o.parse_status == STAT_CLEAN)

  // A start transaction never produces an event
  `BSTR_ASSERT_NXT(a_start_quiet, in_valid_i && !in_stall_o && !out_valid_o && in_data_i.func == FUNC_START, out_data_o.event_res == EVT_NONE && !out_data_o.packet_done)

endmodule

bind bigsize_tlv_stream_router_core bstr_checker u_bstr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
